// File: design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the selection sort with counts block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned CompareWidth = 11;
  localparam int unsigned SwapWidth    = 6;

  typedef struct packed {
    logic                          valid;
    logic signed [ValueWidth-1:0]  value;
  } ssc_elem_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } ssc_state_t;

endpackage

`default_nettype wire

// File: design/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell
// One cell of the sorting chain. It keeps the smaller of its held value and
// the value coming from the left and passes the larger one to the right. In
// shift mode it takes the held value of its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              shift,
  input  wire ssc_pkg::ssc_elem_t link_in,
  input  wire ssc_pkg::ssc_elem_t right_held,
  output ssc_pkg::ssc_elem_t     link_out,
  output ssc_pkg::ssc_elem_t     held
);
  import ssc_pkg::*;

  ssc_elem_t held_next;
  ssc_elem_t pass_next;

  always_comb begin
    held_next = held;
    pass_next = link_in;
    pass_next.valid = 1'b0;
    priority if (shift) begin
      held_next = right_held;
    end else if (link_in.valid) begin
      if (!held.valid) begin
        held_next = link_in;
      end else if (link_in.value < held.value) begin
        held_next = link_in;
        pass_next = held;
      end else begin
        pass_next = link_in;
      end
    end else begin
      pass_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid     <= 1'b0;
      link_out.valid <= 1'b0;
    end else begin
      held.valid     <= held_next.valid;
      link_out.valid <= pass_next.valid;
    end
    held.value     <= held_next.value;
    link_out.value <= pass_next.value;
  end

endmodule

`default_nettype wire

// File: design/selection_sort_with_counts.sv
// ----------------------------------------------------------------------------
// selection_sort_with_counts
// Collects a set of signed values, sorts it ascending in a chain of cells and
// returns the sorted values with the selection sort operation counts.
// ----------------------------------------------------------------------------
// While loading, items are taken back to back until last. After the last
// item the chain is left to settle over the full depth of the cell chain
// that an entering value may have to ripple through. Then results are
// offered, one per cycle while out_ready is high. Reset is synchronous and
// empties every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module selection_sort_with_counts #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [ssc_pkg::ValueWidth-1:0]     value,
  input  wire logic                                      last,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [ssc_pkg::ValueWidth-1:0]          sorted_value,
  output logic                                           final_res,
  output logic [ssc_pkg::CompareWidth-1:0]               compare_count,
  output logic [ssc_pkg::SwapWidth-1:0]                  swap_count,
  output logic                                           overflowed
);
  import ssc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = $clog2(MAX_ITEMS);

  ssc_state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remaining, remaining_next;
  logic [SW-1:0] settle, settle_next;
  logic          overflow, overflow_next;
  logic [CompareWidth-1:0] compare_next;
  logic [SwapWidth-1:0]    swap_next;
  logic [2*CW-1:0]         product;
  logic                    in_fire;
  logic                    room;
  logic                    shift;

  ssc_elem_t link [MAX_ITEMS+1];
  ssc_elem_t held [MAX_ITEMS+1];

  assign in_fire = in_valid && in_ready;
  assign room    = count < CW'(MAX_ITEMS);
  assign shift   = (state == ST_DRAIN) && out_ready;
  assign product = (2*CW)'(count) * (2*CW)'(count - CW'(1));

  assign link[0].valid = in_fire && room;
  assign link[0].value = value;
  assign held[MAX_ITEMS].valid = 1'b0;
  assign held[MAX_ITEMS].value = '0;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    ssc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (shift),
      .link_in    (link[k]),
      .right_held (held[k+1]),
      .link_out   (link[k+1]),
      .held       (held[k])
    );
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    settle_next    = settle;
    overflow_next  = overflow;
    compare_next   = compare_count;
    swap_next      = swap_count;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (room) begin
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (last) begin
            state_next  = ST_SETTLE;
            settle_next = '0;
          end
        end
      end
      ST_SETTLE: begin
        settle_next    = settle + SW'(1);
        remaining_next = count;
        compare_next   = CompareWidth'(product >> 1);
        swap_next      = SwapWidth'(count - CW'(1));
        if (settle == SW'(MAX_ITEMS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          remaining_next = remaining - CW'(1);
          if (remaining == CW'(1)) begin
            state_next    = ST_LOAD;
            count_next    = '0;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      remaining <= '0;
      settle    <= '0;
      overflow  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      settle    <= settle_next;
      overflow  <= overflow_next;
    end
    compare_count <= compare_next;
    swap_count    <= swap_next;
  end

  assign sorted_value = held[0].value;
  assign final_res    = remaining == CW'(1);
  assign overflowed   = overflow;

  a_out_has_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held[0].valid)
    else $error("result offered from an empty head cell");

  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    !link[MAX_ITEMS].valid)
    else $error("value pushed out of the end of the chain");

  a_settled_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> !link[1].valid)
    else $error("chain still moving while results are drained");

  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (remaining <= count && remaining != '0))
    else $error("remaining result count out of range");

endmodule

`default_nettype wire

// File: sim/selection_sort_with_counts_tb.sv
// ----------------------------------------------------------------------------
// selection_sort_with_counts_tb
// Self-checking testbench of the selection sort with counts block.
// ----------------------------------------------------------------------------
// A table of directed sets covers single elements at the value extremes,
// duplicates, pairs in both orders and a set of equal values. Random sets
// follow: a set that exactly fills the store, sets that overflow it, and
// many short sets with random content. Each accepted transaction feeds a
// predictor of the sort, and each sorted value that comes out is compared
// field by field with the oldest prediction. Both sides idle and stall at
// random in several phases.
// ----------------------------------------------------------------------------

module selection_sort_with_counts_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxItems      = 64;
  localparam int IdleLimit     = 4000;
  localparam int RandomItems   = 350;
  localparam int DrainCycles   = 2 * MaxItems + 32;

  localparam int PhaseNoIdle   = 0;
  localparam int PhaseSendIdle = 1;
  localparam int PhaseRecvIdle = 2;
  localparam int PhaseBothIdle = 3;

  typedef struct packed {
    logic signed [ssc_pkg::ValueWidth-1:0]   value;
    logic                                    fin;
    logic [ssc_pkg::CompareWidth-1:0]        cmp;
    logic [ssc_pkg::SwapWidth-1:0]           swp;
    logic                                    ovf;
  } sorted_result_t;

  typedef struct packed {
    logic signed [ssc_pkg::ValueWidth-1:0]   v;
    logic                                    l;
    logic                                    typed;
    logic signed [ssc_pkg::ValueWidth-1:0]   exp_v;
  } stim_row_t;

  logic                                    clk;
  logic                                    rst;
  logic                                    in_valid;
  logic                                    in_ready;
  logic signed [ssc_pkg::ValueWidth-1:0]   value;
  logic                                    last;
  logic                                    out_valid;
  logic                                    out_ready;
  logic signed [ssc_pkg::ValueWidth-1:0]   sorted_value;
  logic                                    final_res;
  logic [ssc_pkg::CompareWidth-1:0]        compare_count;
  logic [ssc_pkg::SwapWidth-1:0]           swap_count;
  logic                                    overflowed;

  sorted_result_t                          pending_sorted_q[$];
  sorted_result_t                          predicted_q[$];
  stim_row_t                               directed_rows[$];

  logic signed [ssc_pkg::ValueWidth-1:0]   held_vals[MaxItems];
  int                                      held_count;
  logic                                    held_dropped;

  int mismatches;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int sets_sent;
  int overflow_sets;
  int results_checked;

  selection_sort_with_counts #(
    .MAX_ITEMS(MaxItems)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sorted_value  (sorted_value),
    .final_res     (final_res),
    .compare_count (compare_count),
    .swap_count    (swap_count),
    .overflowed    (overflowed)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp_val, $realtime);
    mismatches++;
  endtask

  // Collects one element and, when the set closes, sorts it by selection sort
  // with the counts that the block reports and queues one prediction per sorted element.
  task automatic model_accept(input logic signed [ssc_pkg::ValueWidth-1:0] v,
                              input logic l);
    int                                    i;
    int                                    j;
    int                                    min_idx;
    logic signed [ssc_pkg::ValueWidth-1:0] min_v;
    logic [ssc_pkg::CompareWidth-1:0]      cmp;
    logic [ssc_pkg::SwapWidth-1:0]         swp;
    sorted_result_t                        r;
    if (held_count < MaxItems) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (l) begin
      cmp = '0;
      swp = '0;
      for (i = 0; i + 1 < held_count; i++) begin
        min_idx = i;
        min_v   = held_vals[i];
        for (j = i + 1; j < held_count; j++) begin
          if (held_vals[j] < min_v) begin
            min_v   = held_vals[j];
            min_idx = j;
          end
          cmp = cmp + 1'b1;
        end
        swp = swp + 1'b1;
        held_vals[min_idx] = held_vals[i];
        held_vals[i]       = min_v;
      end
      for (i = 0; i < held_count; i++) begin
        r.value = held_vals[i];
        r.fin   = (i + 1 == held_count);
        r.cmp   = cmp;
        r.swp   = swp;
        r.ovf   = held_dropped;
        predicted_q.insert(predicted_q.size(), r);
      end
      if (held_dropped) overflow_sets++;
      sets_sent++;
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input logic signed [ssc_pkg::ValueWidth-1:0] v,
                           input logic l, input logic typed,
                           input logic signed [ssc_pkg::ValueWidth-1:0] exp_v);
    sorted_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    model_accept(v, l);
    if (typed) begin
      predicted_q.delete();
      r.value = exp_v;
      r.fin   = 1'b1;
      r.cmp   = '0;
      r.swp   = '0;
      r.ovf   = 1'b0;
      pending_sorted_q.insert(pending_sorted_q.size(), r);
    end else begin
      while (predicted_q.size() != 0) begin
        pending_sorted_q.insert(pending_sorted_q.size(), predicted_q.pop_front());
      end
    end
  endtask

  task automatic set_phase(input int p);
    case (p)
      PhaseNoIdle: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PhaseSendIdle: begin
        send_idle_pct  = 51;
        recv_stall_pct = 0;
      end
      PhaseRecvIdle: begin
        send_idle_pct  = 0;
        recv_stall_pct = 51;
      end
      default: begin
        send_idle_pct  = 37;
        recv_stall_pct = 37;
      end
    endcase
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted_q.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t row(input logic [31:0] v, input logic l,
                                    input logic typed);
    stim_row_t s;
    s.v     = v;
    s.l     = l;
    s.typed = typed;
    s.exp_v = v;
    return s;
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] r;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0: r = 32'h8000_0000;
          1: r = 32'h7fff_ffff;
          2: r = 32'h0000_0000;
          3: r = 32'hffff_ffff;
          default: r = 32'h0000_0001;
        endcase
      end
      1: r = $urandom_range(15) - 8;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sorted_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_sorted_q.size() == 0) begin
        report_mismatch("unexpected sorted value", sorted_value, '0);
      end else begin
        e = pending_sorted_q.pop_front();
        results_checked++;
        if (sorted_value !== e.value) report_mismatch("sorted_value", sorted_value, e.value);
        if (final_res !== e.fin) report_mismatch("final_res", final_res, e.fin);
        if (compare_count !== e.cmp) report_mismatch("compare_count", compare_count, e.cmp);
        if (swap_count !== e.swp) report_mismatch("swap_count", swap_count, e.swp);
        if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d cycles without a transaction", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int n;
    int set_idx;
    int rand_items;
    rst             = 1'b1;
    in_valid        = 1'b0;
    value           = '0;
    last            = 1'b0;
    held_count      = 0;
    held_dropped    = 1'b0;
    items_sent      = 0;
    sets_sent       = 0;
    overflow_sets   = 0;
    set_phase(PhaseNoIdle);

    directed_rows.insert(directed_rows.size(), row(32'h8000_0000, 1'b1, 1'b1));
    directed_rows.insert(directed_rows.size(), row(32'h7fff_ffff, 1'b1, 1'b1));
    directed_rows.insert(directed_rows.size(), row(32'h0000_0000, 1'b1, 1'b1));
    directed_rows.insert(directed_rows.size(), row(32'hffff_ffff, 1'b1, 1'b1));
    directed_rows.insert(directed_rows.size(), row(32'h7fff_ffff, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h8000_0000, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'hffff_ffff, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h0000_0000, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h8000_0000, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h0000_0001, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h7fff_ffff, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'hffff_fffb, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h0000_0005, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h0000_0005, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'hffff_fffb, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h1234_5678, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h1234_5678, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h1234_5678, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h1234_5678, 1'b1, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h5555_5555, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'haaaa_aaaa, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h5555_5555, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'haaaa_aaaa, 1'b0, 1'b0));
    directed_rows.insert(directed_rows.size(), row(32'h0000_0000, 1'b1, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < directed_rows.size(); k++) begin
      send_item(directed_rows[k].v, directed_rows[k].l, directed_rows[k].typed,
                directed_rows[k].exp_v);
    end
    wait_results_drained();

    set_idx    = 0;
    rand_items = 0;
    while (rand_items < RandomItems) begin
      set_phase((set_idx / 2) % 4);
      case (set_idx)
        0: n = MaxItems;
        1: n = MaxItems + 1;
        2: n = MaxItems + 6;
        default: n = $urandom_range(1, 8);
      endcase
      for (k = 0; k < n; k++) begin
        send_item(rand_value(), (k == n - 1), 1'b0, '0);
      end
      rand_items += n;
      set_idx++;
      if (set_idx % 10 == 0) wait_results_drained();
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (pending_sorted_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d transactions in %0d sets, %0d of them overflowing the store.",
             items_sent, sets_sent, overflow_sets);
    $display("Checked %0d sorted values under four idle and stall phases.", results_checked);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ssc_pkg.sv
design/ssc_cell.sv
design/selection_sort_with_counts.sv
sim/selection_sort_with_counts_tb.sv
